### rtl/core/cablt_pkg.sv
// ----------------------------------------------------------------------------
// cablt_pkg
// Shared widths, register indexes and the configuration struct of the
// clipped alpha-test blitter.
// ----------------------------------------------------------------------------
package cablt_pkg;

   localparam int MaxDimDefault = 4096;

   localparam int PixelW   = 32;
   localparam int AddrW    = 24;
   localparam int DimW     = 13;
   localparam int PosW     = 14;
   localparam int AlignW   = 12;
   localparam int AlphaLsb = 24;
   localparam int AlphaW   = 8;
   localparam int ProdW    = 2 * DimW;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 14;

   localparam logic [CsrIdxW-1:0] CsrDestWidth    = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrDestHeight   = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrBitmapWidth  = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrBitmapHeight = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrPosX         = 3'd4;
   localparam logic [CsrIdxW-1:0] CsrPosY         = 3'd5;
   localparam logic [CsrIdxW-1:0] CsrAlignX       = 3'd6;
   localparam logic [CsrIdxW-1:0] CsrAlignY       = 3'd7;

   typedef struct packed {
      logic [DimW-1:0]   dest_width;
      logic [DimW-1:0]   dest_height;
      logic [DimW-1:0]   bitmap_width;
      logic [DimW-1:0]   bitmap_height;
      logic [PosW-1:0]   pos_x;
      logic [PosW-1:0]   pos_y;
      logic [AlignW-1:0] align_x;
      logic [AlignW-1:0] align_y;
   } cfg_type;

   function automatic int cnt_width(input int max_dim);
      return $clog2(max_dim);
   endfunction

   function automatic int off_width(input int max_dim);
      int w;
      w = $clog2(max_dim) + 1;
      if (w < PosW) begin
         w = PosW;
      end
      return w + 2;
   endfunction

endpackage

### rtl/core/cablt_pos.sv
// ----------------------------------------------------------------------------
// cablt_pos
// Input stage: column and row counters with wrap at the bitmap size, and the
// destination offset of each accepted pixel.
// ----------------------------------------------------------------------------
module cablt_pos #(
   parameter int MAX_DIM = cablt_pkg::MaxDimDefault
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cablt_pkg::cfg_type                     cfg,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [cablt_pkg::PixelW-1:0]           req_source_pixel,
   input  logic                                   down_ready,
   output logic                                   pos_valid,
   output logic [cablt_pkg::PixelW-1:0]           pos_pixel,
   output logic [cablt_pkg::off_width(MAX_DIM)-1:0] pos_dx,
   output logic [cablt_pkg::off_width(MAX_DIM)-1:0] pos_dy
);

   localparam int CntW  = cablt_pkg::cnt_width(MAX_DIM);
   localparam int OffW  = cablt_pkg::off_width(MAX_DIM);
   localparam int SizeW = (CntW + 1 > cablt_pkg::DimW) ? CntW + 1 : cablt_pkg::DimW;

   logic [SizeW-1:0]             bw;
   logic [SizeW-1:0]             bh;
   logic [CntW-1:0]              col_ff, col_in, col_eff;
   logic [CntW-1:0]              row_ff, row_in, row_eff;
   logic [SizeW-1:0]             col_inc, row_inc;
   logic                         col_wrap;
   logic                         valid_ff, valid_in;
   logic [cablt_pkg::PixelW-1:0] pixel_ff;
   logic [OffW-1:0]              dx_ff, dx_in, dy_ff, dy_in;
   logic                         accept;

   always_comb begin
      bw = SizeW'(cfg.bitmap_width);
      bh = SizeW'(cfg.bitmap_height);
      if (cfg.bitmap_width == '0) begin
         bw = SizeW'(1);
      end else if (SizeW'(cfg.bitmap_width) > SizeW'(MAX_DIM)) begin
         bw = SizeW'(MAX_DIM);
      end
      if (cfg.bitmap_height == '0) begin
         bh = SizeW'(1);
      end else if (SizeW'(cfg.bitmap_height) > SizeW'(MAX_DIM)) begin
         bh = SizeW'(MAX_DIM);
      end
   end

   assign req_ready = !valid_ff || down_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      col_eff  = (SizeW'(col_ff) >= bw) ? '0 : col_ff;
      row_eff  = (SizeW'(row_ff) >= bh) ? '0 : row_ff;
      col_inc  = SizeW'(col_eff) + SizeW'(1);
      col_wrap = col_inc >= bw;
      col_in   = col_wrap ? '0 : col_inc[CntW-1:0];
      row_inc  = SizeW'(row_eff) + (col_wrap ? SizeW'(1) : SizeW'(0));
      row_in   = (row_inc >= bh) ? '0 : row_inc[CntW-1:0];
      dx_in    = {{(OffW - cablt_pkg::PosW){cfg.pos_x[cablt_pkg::PosW-1]}}, cfg.pos_x}
                 - OffW'(cfg.align_x) + OffW'(col_eff);
      dy_in    = {{(OffW - cablt_pkg::PosW){cfg.pos_y[cablt_pkg::PosW-1]}}, cfg.pos_y}
                 - OffW'(cfg.align_y) + OffW'(row_eff);
      valid_in = accept || (valid_ff && !down_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pixel_ff <= req_source_pixel;
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
      end
   end

   assign pos_valid = valid_ff;
   assign pos_pixel = pixel_ff;
   assign pos_dx    = dx_ff;
   assign pos_dy    = dy_ff;

endmodule

### rtl/core/cablt_emit.sv
// ----------------------------------------------------------------------------
// cablt_emit
// Output stage: clip against the destination, drop transparent pixels and
// form the linear destination address into the result register.
// ----------------------------------------------------------------------------
module cablt_emit #(
   parameter int MAX_DIM = cablt_pkg::MaxDimDefault
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cablt_pkg::cfg_type                     cfg,
   input  logic                                   pos_valid,
   output logic                                   pos_ready,
   input  logic [cablt_pkg::PixelW-1:0]           pos_pixel,
   input  logic [cablt_pkg::off_width(MAX_DIM)-1:0] pos_dx,
   input  logic [cablt_pkg::off_width(MAX_DIM)-1:0] pos_dy,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [cablt_pkg::AddrW-1:0]            rsp_dest_address,
   output logic [cablt_pkg::PixelW-1:0]           rsp_pixel_value
);

   localparam int OffW = cablt_pkg::off_width(MAX_DIM);
   localparam int DimW = cablt_pkg::DimW;

   logic                           take;
   logic                           keep;
   logic [cablt_pkg::AlphaW-1:0]   alpha;
   logic [cablt_pkg::ProdW-1:0]    addr_full;
   logic                           valid_ff, valid_in;
   logic [cablt_pkg::AddrW-1:0]    addr_ff;
   logic [cablt_pkg::PixelW-1:0]   pixel_ff;

   assign take      = !valid_ff || rsp_ready;
   assign pos_ready = take;

   always_comb begin
      alpha     = pos_pixel[cablt_pkg::AlphaLsb +: cablt_pkg::AlphaW];
      keep      = pos_valid && !pos_dx[OffW-1] && !pos_dy[OffW-1]
                  && (pos_dx < OffW'(cfg.dest_width))
                  && (pos_dy < OffW'(cfg.dest_height))
                  && (alpha != '0);
      addr_full = cablt_pkg::ProdW'(pos_dy[DimW-1:0]) * cablt_pkg::ProdW'(cfg.dest_width)
                  + cablt_pkg::ProdW'(pos_dx[DimW-1:0]);
      valid_in  = take ? keep : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && keep) begin
         addr_ff  <= addr_full[cablt_pkg::AddrW-1:0];
         pixel_ff <= pos_pixel;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_dest_address = addr_ff;
   assign rsp_pixel_value  = pixel_ff;

endmodule

### rtl/core/clipped_alpha_test_blit.sv
// ----------------------------------------------------------------------------
// clipped_alpha_test_blit
// Clipped, alpha-tested bitmap blitter.
//
// Feed bitmap ARGB pixels in raster order on the req_ channel, one per
// transfer. A column and a row counter follow the source position and wrap
// at the bitmap size. Each pixel that lands inside the destination buffer
// and has nonzero alpha leaves on the rsp_ channel as one write: its linear
// destination address and the unchanged pixel. Other pixels are dropped.
// Program the csr_ registers only while the block is idle.
// A pixel goes from the req_ transfer into an input register, which holds
// the pixel and its destination offset, and then into a result register,
// which holds the write that rsp_valid announces. Throughput is one pixel
// per cycle while the receiver does not stall; the single address
// multiply sits in the result stage.
// Reset clears the counters, empties both stages and returns the registers
// to a 1x1 destination and bitmap at position zero. When the receiver
// stalls, the result register holds and req_ready falls once the input
// register is full as well.
// ----------------------------------------------------------------------------
module clipped_alpha_test_blit #(
   parameter int MAX_DIM = cablt_pkg::MaxDimDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [cablt_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [cablt_pkg::CsrDataW-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cablt_pkg::PixelW-1:0]     req_source_pixel,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cablt_pkg::AddrW-1:0]      rsp_dest_address,
   output logic [cablt_pkg::PixelW-1:0]     rsp_pixel_value
);

   localparam int OffW = cablt_pkg::off_width(MAX_DIM);

   cablt_pkg::cfg_type           cfg_ff, cfg_in;
   logic                         pos_valid;
   logic                         pos_ready;
   logic [cablt_pkg::PixelW-1:0] pos_pixel;
   logic [OffW-1:0]              pos_dx;
   logic [OffW-1:0]              pos_dy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            cablt_pkg::CsrDestWidth: begin
               cfg_in.dest_width = csr_wdata[cablt_pkg::DimW-1:0];
            end
            cablt_pkg::CsrDestHeight: begin
               cfg_in.dest_height = csr_wdata[cablt_pkg::DimW-1:0];
            end
            cablt_pkg::CsrBitmapWidth: begin
               cfg_in.bitmap_width = csr_wdata[cablt_pkg::DimW-1:0];
            end
            cablt_pkg::CsrBitmapHeight: begin
               cfg_in.bitmap_height = csr_wdata[cablt_pkg::DimW-1:0];
            end
            cablt_pkg::CsrPosX: begin
               cfg_in.pos_x = csr_wdata[cablt_pkg::PosW-1:0];
            end
            cablt_pkg::CsrPosY: begin
               cfg_in.pos_y = csr_wdata[cablt_pkg::PosW-1:0];
            end
            cablt_pkg::CsrAlignX: begin
               cfg_in.align_x = csr_wdata[cablt_pkg::AlignW-1:0];
            end
            cablt_pkg::CsrAlignY: begin
               cfg_in.align_y = csr_wdata[cablt_pkg::AlignW-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_width    <= cablt_pkg::DimW'(1);
         cfg_ff.dest_height   <= cablt_pkg::DimW'(1);
         cfg_ff.bitmap_width  <= cablt_pkg::DimW'(1);
         cfg_ff.bitmap_height <= cablt_pkg::DimW'(1);
         cfg_ff.pos_x         <= '0;
         cfg_ff.pos_y         <= '0;
         cfg_ff.align_x       <= '0;
         cfg_ff.align_y       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cablt_pos #(
      .MAX_DIM (MAX_DIM)
   ) u_pos (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_source_pixel (req_source_pixel),
      .down_ready       (pos_ready),
      .pos_valid        (pos_valid),
      .pos_pixel        (pos_pixel),
      .pos_dx           (pos_dx),
      .pos_dy           (pos_dy)
   );

   cablt_emit #(
      .MAX_DIM (MAX_DIM)
   ) u_emit (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .pos_valid        (pos_valid),
      .pos_ready        (pos_ready),
      .pos_pixel        (pos_pixel),
      .pos_dx           (pos_dx),
      .pos_dy           (pos_dy),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_dest_address (rsp_dest_address),
      .rsp_pixel_value  (rsp_pixel_value)
   );

endmodule
